FILE: rtl/alpha_mask_blend_blit_macros.svh
// Assertion helpers used by the checker file.
`ifndef ALPHA_MASK_BLEND_BLIT_MACROS_SVH
`define ALPHA_MASK_BLEND_BLIT_MACROS_SVH

// Check a property on a given clock, off while the given reset is high.
`define AMBB_ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("alpha_mask_blend_blit check failed");

// Check a property on the block clock and reset.
`define AMBB_ASSERT(lbl, prop) \
   `AMBB_ASSERT_CLK(lbl, clock, reset, prop)

`endif

FILE: rtl/ambb_pkg.sv
`default_nettype none
package ambb_pkg;

   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;
   localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
   localparam int W_BITS     = $clog2(MAX_WIDTH + 1);
   localparam int H_BITS     = $clog2(MAX_HEIGHT + 1);
   localparam int XI_BITS    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int YI_BITS    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   localparam int PIX_W      = 24;
   localparam int CH_BITS    = 8;
   localparam int NUM_CH     = PIX_W / CH_BITS;
   localparam logic [CH_BITS-1:0] CH_MAX = 8'hFF;
   localparam logic [8:0] ROW_LIMIT = 9'd511;

   localparam int REQ_DATA_W = 48;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_BLEND = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      REG_DST_WIDTH  = 3'd0,
      REG_DST_HEIGHT = 3'd1,
      REG_OFFSET_X   = 3'd2,
      REG_OFFSET_Y   = 3'd3,
      REG_MASK_WIDTH = 3'd4,
      REG_FILL_COLOR = 3'd5,
      REG_SPARE_6    = 3'd6,
      REG_SPARE_7    = 3'd7
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADDR,
      ST_READ,
      ST_BLEND,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [6:0] dst_width;
      logic [6:0] dst_height;
      logic [8:0] offset_x;
      logic [8:0] offset_y;
      logic [7:0] mask_width;
   } geom_type;

   typedef struct packed {
      logic              lands;
      logic [ADDR_W-1:0] addr;
   } walk_type;

endpackage
`default_nettype wire

FILE: rtl/ambb_frame_ram.sv
`default_nettype none
module ambb_frame_ram #(
   parameter int DEPTH  = 4096,
   parameter int WIDTH  = 24,
   parameter int ADDR_W = 12
) (
   input  logic              clock,
   input  logic              we,
   input  logic              re,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wdata,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

FILE: rtl/ambb_mask_walk.sv
`default_nettype none
module ambb_mask_walk (
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  logic               first,
   input  ambb_pkg::geom_type geom,
   output ambb_pkg::walk_type walk
);
   import ambb_pkg::*;

   logic [7:0]         col_ff, col_in;
   logic [8:0]         row_ff, row_in;
   logic [XI_BITS-1:0] xpos_ff, xpos_in;
   logic [YI_BITS-1:0] ypos_ff, ypos_in;
   logic               inside_ff, inside_in;

   logic [7:0]         col_eff;
   logic [8:0]         row_eff;
   logic signed [9:0]  xs;
   logic signed [10:0] ys;
   logic [W_BITS-1:0]  w;
   logic [H_BITS-1:0]  h;
   logic [8:0]         limit;
   logic [8:0]         col_inc;

   always_comb begin
      w = (32'(geom.dst_width) > MAX_WIDTH) ? W_BITS'(MAX_WIDTH) : W_BITS'(geom.dst_width);
      h = (32'(geom.dst_height) > MAX_HEIGHT) ? H_BITS'(MAX_HEIGHT)
                                              : H_BITS'(geom.dst_height);
      col_eff = first ? 8'd0 : col_ff;
      row_eff = first ? 9'd0 : row_ff;
      xs = $signed({geom.offset_x[8], geom.offset_x}) + $signed({2'b00, col_eff});
      ys = $signed({{2{geom.offset_y[8]}}, geom.offset_y}) + $signed({2'b00, row_eff});
      inside_in = !xs[9] && !ys[10] && (32'(xs[8:0]) < 32'(w)) && (32'(ys[9:0]) < 32'(h));
      xpos_in = XI_BITS'(xs[8:0]);
      ypos_in = YI_BITS'(ys[9:0]);
      limit = (geom.mask_width == 8'd0) ? 9'd256 : {1'b0, geom.mask_width};
      col_inc = {1'b0, col_eff} + 9'd1;
      if (col_inc >= limit) begin
         col_in = 8'd0;
         row_in = (row_eff < ROW_LIMIT) ? row_eff + 9'd1 : row_eff;
      end else begin
         col_in = col_inc[7:0];
         row_in = row_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= 8'd0;
         row_ff <= 9'd0;
         inside_ff <= 1'b0;
      end else if (take) begin
         col_ff <= col_in;
         row_ff <= row_in;
         inside_ff <= inside_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         xpos_ff <= xpos_in;
         ypos_ff <= ypos_in;
      end
   end

   assign walk.lands = inside_ff;
   assign walk.addr = ADDR_W'(ypos_ff) * ADDR_W'(w) + ADDR_W'(xpos_ff);

endmodule
`default_nettype wire

FILE: rtl/ambb_blend.sv
`default_nettype none
module ambb_blend (
   input  logic                        clock,
   input  logic                        load,
   input  logic [ambb_pkg::PIX_W-1:0]  color,
   input  logic [ambb_pkg::PIX_W-1:0]  dst,
   input  logic [7:0]                  alpha,
   output logic [ambb_pkg::PIX_W-1:0]  blended
);
   import ambb_pkg::*;

   logic [PIX_W-1:0] blended_ff, blended_in;
   logic [CH_BITS-1:0] inv;
   logic [2*CH_BITS:0] sum [NUM_CH];

   always_comb begin
      inv = CH_MAX - alpha;
      for (int i = 0; i < NUM_CH; i++) begin
         sum[i] = (2*CH_BITS+1)'(color[i*CH_BITS +: CH_BITS] * alpha)
                + (2*CH_BITS+1)'(dst[i*CH_BITS +: CH_BITS] * inv);
         blended_in[i*CH_BITS +: CH_BITS] = sum[i][2*CH_BITS-1:CH_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         blended_ff <= blended_in;
      end
   end

   assign blended = blended_ff;

endmodule
`default_nettype wire

FILE: rtl/alpha_mask_blend_blit.sv
// alpha_mask_blend_blit: 24-bit RGB frame memory with a streaming alpha-mask blender.
// Request channel req_*: tuser carries the opcode (write pixel, read pixel, mask byte),
// tdata the pixel index, pixel value, mask byte and first-byte flag.
// Response channel rsp_*: one item per request, read data and a landed flag.
// Registers on the csr_* port set the destination size, the signed mask offset,
// the mask row length and the fill color; write them only while the block is idle.
// Every request goes through address, memory read, blend and write-back steps on a
// single-port frame memory; the response is registered at the write-back step, and
// the block takes a new request only once the last one has left the write-back step.
// A mask byte maps through the position counter and offset onto a pixel; bytes that
// fall outside the destination leave memory untouched and report landed low.
// Reset clears the position counter and returns the registers to their reset values;
// frame memory is not cleared. A stalled response holds in its output register; the
// next request may still be accepted, and its result waits in the last step until the register frees.
`default_nettype none
module alpha_mask_blend_blit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // pixel_index[11:0], pixel_value[35:12], mask_value[43:36], mask_first[44], zero fill
   input  logic [ambb_pkg::REQ_DATA_W-1:0]      req_tdata,
   // opcode[1:0]
   input  logic [ambb_pkg::REQ_USER_W-1:0]      req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // read_data[23:0], landed[24], zero fill
   output logic [ambb_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [ambb_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [ambb_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [ambb_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import ambb_pkg::*;

   state_type state_ff, state_in;

   geom_type         geom_ff;
   logic [PIX_W-1:0] fill_ff;
   reg_index_type    csr_index;
   logic             csr_write;

   opcode_type        op_ff;
   logic [11:0]       index_ff;
   logic [PIX_W-1:0]  value_ff;
   logic [7:0]        alpha_ff;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              hit_ff, hit_in;

   logic             rsp_valid_ff;
   logic [PIX_W-1:0] read_data_ff, read_data_in;
   logic             landed_ff, landed_in;

   logic             req_take;
   logic             walk_take;
   logic             out_free;
   logic             addr_load;
   logic             ram_re;
   logic             ram_we;
   logic             blend_load;
   logic             done_fire;
   logic [PIX_W-1:0] ram_wdata;
   logic [PIX_W-1:0] ram_rdata;
   logic [PIX_W-1:0] blended;
   walk_type         walk;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_index = reg_index_type'(csr_paddr[4:2]);
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         geom_ff.dst_width <= 7'd64;
         geom_ff.dst_height <= 7'd64;
         geom_ff.offset_x <= 9'd0;
         geom_ff.offset_y <= 9'd0;
         geom_ff.mask_width <= 8'd1;
         fill_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_DST_WIDTH:  geom_ff.dst_width <= csr_pwdata[6:0];
            REG_DST_HEIGHT: geom_ff.dst_height <= csr_pwdata[6:0];
            REG_OFFSET_X:   geom_ff.offset_x <= csr_pwdata[8:0];
            REG_OFFSET_Y:   geom_ff.offset_y <= csr_pwdata[8:0];
            REG_MASK_WIDTH: geom_ff.mask_width <= csr_pwdata[7:0];
            REG_FILL_COLOR: fill_ff <= csr_pwdata[PIX_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_DST_WIDTH:  csr_prdata = CSR_DATA_W'(geom_ff.dst_width);
         REG_DST_HEIGHT: csr_prdata = CSR_DATA_W'(geom_ff.dst_height);
         REG_OFFSET_X:   csr_prdata = CSR_DATA_W'(geom_ff.offset_x);
         REG_OFFSET_Y:   csr_prdata = CSR_DATA_W'(geom_ff.offset_y);
         REG_MASK_WIDTH: csr_prdata = CSR_DATA_W'(geom_ff.mask_width);
         REG_FILL_COLOR: csr_prdata = CSR_DATA_W'(fill_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // sequencer
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign req_take = req_tvalid && req_tready;
   assign walk_take = req_take && (opcode_type'(req_tuser) == OP_BLEND);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_take) state_in = ST_ADDR;
         ST_ADDR:  state_in = ST_READ;
         ST_READ:  state_in = ST_BLEND;
         ST_BLEND: state_in = ST_DONE;
         ST_DONE:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      addr_load = 1'b0;
      ram_re = 1'b0;
      blend_load = 1'b0;
      done_fire = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_tready = 1'b1;
         ST_ADDR:  addr_load = 1'b1;
         ST_READ:  ram_re = 1'b1;
         ST_BLEND: blend_load = 1'b1;
         ST_DONE:  done_fire = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= OP_NONE;
      end else if (req_take) begin
         op_ff <= opcode_type'(req_tuser);
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         index_ff <= req_tdata[11:0];
         value_ff <= req_tdata[35:12];
         alpha_ff <= req_tdata[43:36];
      end
   end

   ambb_mask_walk u_walk (
      .clock (clock),
      .reset (reset),
      .take  (walk_take),
      .first (req_tdata[44]),
      .geom  (geom_ff),
      .walk  (walk)
   );

   always_comb begin
      case (op_ff)
         OP_BLEND: begin
            addr_in = walk.addr;
            hit_in = walk.lands;
         end
         OP_WRITE, OP_READ: begin
            addr_in = ADDR_W'(index_ff);
            hit_in = 32'(index_ff) < STORE_SIZE;
         end
         default: begin
            addr_in = ADDR_W'(index_ff);
            hit_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (addr_load) begin
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (addr_load) begin
         addr_ff <= addr_in;
      end
   end

   // frame memory and blend
   assign ram_we = done_fire && hit_ff && (op_ff == OP_WRITE || op_ff == OP_BLEND);
   assign ram_wdata = (op_ff == OP_WRITE) ? value_ff : blended;

   ambb_frame_ram #(
      .DEPTH  (STORE_SIZE),
      .WIDTH  (PIX_W),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (addr_ff),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   ambb_blend u_blend (
      .clock   (clock),
      .load    (blend_load),
      .color   (fill_ff),
      .dst     (ram_rdata),
      .alpha   (alpha_ff),
      .blended (blended)
   );

   // response register
   assign read_data_in = (op_ff == OP_READ && hit_ff) ? ram_rdata : '0;
   assign landed_in = (op_ff == OP_BLEND) && hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done_fire) begin
         read_data_ff <= read_data_in;
         landed_ff <= landed_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {{(RSP_DATA_W - PIX_W - 1){1'b0}}, landed_ff, read_data_ff};

endmodule
`default_nettype wire

FILE: rtl/ambb_checker.sv
`default_nettype none
`include "alpha_mask_blend_blit_macros.svh"
module ambb_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [ambb_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import ambb_pkg::*;

   `AMBB_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
   `AMBB_ASSERT(a_landed_no_data, rsp_tvalid && rsp_tdata[PIX_W] |-> rsp_tdata[PIX_W-1:0] == '0)
   `AMBB_ASSERT(a_one_at_a_time, req_tvalid && req_tready |=> !req_tready)
   `AMBB_ASSERT(a_no_instant_rsp, req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)

endmodule

bind alpha_mask_blend_blit ambb_checker u_checker (.*);
`default_nettype wire
